### hdl/srp_pkg.sv
// Shared types and constants for the shelf rectangle packer.
// No dependencies; used by every module of the block.
package srp_pkg;

	localparam int MAX_RECTS_DEF = 32;
	localparam int MAX_SIDE_DEF  = 4096;

	localparam int SIDE_W = 13;
	localparam int IDX_W  = 6;
	localparam int X_W    = 16;
	localparam int Y_W    = 18;
	localparam int AREA_W = 30;
	localparam int ROOT_W = 16;

	localparam logic [AREA_W-1:0] AREA_MAX = {AREA_W{1'b1}};

	// One rectangle as held in a sorting cell
	typedef struct packed {
		logic              valid;
		logic [IDX_W-1:0]  idx;
		logic [SIDE_W-1:0] w;
		logic [SIDE_W-1:0] h;
		logic [X_W-1:0]    x;
		logic [Y_W-1:0]    y;
	} rect_t;

	// Per-cycle command to the cell chain
	typedef struct packed {
		logic ins_en;
		logic shift_en;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_ROOT,
		ST_PLACE,
		ST_EMIT
	} state_t;

endpackage

### hdl/shelf_rectangle_packer.sv
// Shelf rectangle packer: loads one rectangle per cycle into a sorted cell chain while
// in_ready is high (load state). After the last request: square root of the area, then the
// atlas width as the larger of root and widest side; placement (the chain rotates once
// through the shelf cursor); then one result per cycle while out_ready is high.
// Asynchronous active-low reset empties the chain and returns to loading.
module shelf_rectangle_packer #(
	parameter int MAX_RECTS = srp_pkg::MAX_RECTS_DEF,
	parameter int MAX_SIDE  = srp_pkg::MAX_SIDE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [srp_pkg::SIDE_W-1:0]  rect_width,
	input  logic [srp_pkg::SIDE_W-1:0]  rect_height,
	input  logic                        is_last_rect,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [srp_pkg::IDX_W-1:0]   rect_index,
	output logic [srp_pkg::X_W-1:0]     pos_x,
	output logic [srp_pkg::Y_W-1:0]     pos_y,
	output logic [srp_pkg::X_W-1:0]     atlas_span,
	output logic [srp_pkg::Y_W-1:0]     atlas_height,
	output logic                        is_last_result
);

	localparam int CNT_W = $clog2(MAX_RECTS + 1);
	localparam int ROT_W = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

	srp_pkg::state_t state_q, state_d;

	logic [CNT_W-1:0]          count_q, rem_q;
	logic [ROT_W-1:0]          rot_q;
	logic [srp_pkg::AREA_W-1:0] area_q, area_d;
	logic [srp_pkg::SIDE_W-1:0] widest_q;
	logic [srp_pkg::X_W-1:0]   aw_q, cx_q;
	logic [srp_pkg::Y_W-1:0]   cy_q;
	logic [srp_pkg::SIDE_W-1:0] shelf_q;

	logic in_acc, out_acc, room;
	logic [srp_pkg::SIDE_W-1:0] w_sat, h_sat;
	logic [2*srp_pkg::SIDE_W-1:0] prod;
	logic [srp_pkg::AREA_W:0]   sum;
	logic sq_done;
	logic [srp_pkg::ROOT_W-1:0] sq_root;

	srp_pkg::cell_ctl_t ctl;
	srp_pkg::rect_t new_item, tail_item, placed;
	srp_pkg::rect_t cells [MAX_RECTS];
	logic           takes [MAX_RECTS];

	logic [srp_pkg::X_W:0] nx;
	logic                  new_shelf;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;
	assign room    = count_q < CNT_W'(MAX_RECTS);

	// Clamp sides and accumulate the saturating area
	assign w_sat = (int'(rect_width) > MAX_SIDE) ? srp_pkg::SIDE_W'(MAX_SIDE) : rect_width;
	assign h_sat = (int'(rect_height) > MAX_SIDE) ? srp_pkg::SIDE_W'(MAX_SIDE) : rect_height;
	assign prod  = w_sat * h_sat;
	assign sum   = (srp_pkg::AREA_W+1)'(area_q) + (srp_pkg::AREA_W+1)'(prod);
	assign area_d = (room && sum > (srp_pkg::AREA_W+1)'(srp_pkg::AREA_MAX))
		? srp_pkg::AREA_MAX : (room ? sum[srp_pkg::AREA_W-1:0] : area_q);

	always_comb begin
		new_item       = '0;
		new_item.valid = 1'b1;
		new_item.idx   = srp_pkg::IDX_W'(count_q);
		new_item.w     = w_sat;
		new_item.h     = h_sat;
	end

	srp_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_acc && is_last_rect),
		.value  (area_d),
		.done   (sq_done),
		.root   (sq_root)
	);

	// Place the head rectangle on the current shelf or open a new one
	assign nx        = (srp_pkg::X_W+1)'(cx_q) + (srp_pkg::X_W+1)'(cells[0].w);
	assign new_shelf = nx >= (srp_pkg::X_W+1)'(aw_q);
	always_comb begin
		placed = cells[0];
		if (new_shelf) begin
			placed.x = '0;
			placed.y = cy_q + srp_pkg::Y_W'(shelf_q);
		end else begin
			placed.x = cx_q;
			placed.y = cy_q;
		end
	end

	assign ctl.ins_en   = in_acc && room;
	assign ctl.shift_en = (state_q == srp_pkg::ST_PLACE) || out_acc;
	always_comb begin
		tail_item = '0;
		if (state_q == srp_pkg::ST_PLACE) begin
			tail_item = placed;
		end
	end

	// Sorted chain, tallest at the head
	for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
		srp_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.new_item (new_item),
			.up_item  ((i == 0) ? new_item : cells[(i == 0) ? 0 : i-1]),
			.up_take  ((i == 0) ? 1'b0 : takes[(i == 0) ? 0 : i-1]),
			.dn_item  ((i == MAX_RECTS-1) ? tail_item : cells[(i == MAX_RECTS-1) ? i : i+1]),
			.item     (cells[i]),
			.take     (takes[i])
		);
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srp_pkg::ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			srp_pkg::ST_LOAD:  if (in_acc && is_last_rect) state_d = srp_pkg::ST_ROOT;
			srp_pkg::ST_ROOT:  if (sq_done) state_d = srp_pkg::ST_PLACE;
			srp_pkg::ST_PLACE: if (rot_q == ROT_W'(MAX_RECTS-1)) state_d = srp_pkg::ST_EMIT;
			srp_pkg::ST_EMIT:  if (out_acc && rem_q == CNT_W'(1)) state_d = srp_pkg::ST_LOAD;
			default:           state_d = srp_pkg::ST_LOAD;
		endcase
	end

	// Load bookkeeping, atlas width, shelf cursor and result countdown
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			area_q   <= '0;
			widest_q <= '0;
			rem_q    <= '0;
			rot_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			shelf_q  <= '0;
			aw_q     <= '0;
		end else begin
			if (ctl.ins_en) begin
				count_q <= count_q + CNT_W'(1);
				area_q  <= area_d;
				if (w_sat > widest_q) widest_q <= w_sat;
			end
			if (state_q == srp_pkg::ST_ROOT && sq_done) begin
				aw_q  <= (srp_pkg::ROOT_W'(widest_q) > sq_root) ? srp_pkg::X_W'(widest_q)
					: srp_pkg::X_W'(sq_root);
				rot_q   <= '0;
				cx_q    <= '0;
				cy_q    <= '0;
				shelf_q <= '0;
				rem_q   <= count_q;
			end
			if (state_q == srp_pkg::ST_PLACE) begin
				rot_q <= rot_q + ROT_W'(1);
				if (cells[0].valid) begin
					if (new_shelf) begin
						cx_q    <= srp_pkg::X_W'(cells[0].w);
						cy_q    <= placed.y;
						shelf_q <= cells[0].h;
					end else begin
						cx_q <= nx[srp_pkg::X_W-1:0];
						if (cells[0].h > shelf_q) shelf_q <= cells[0].h;
					end
				end
			end
			if (out_acc) begin
				rem_q <= rem_q - CNT_W'(1);
				if (rem_q == CNT_W'(1)) begin
					count_q  <= '0;
					area_q   <= '0;
					widest_q <= '0;
				end
			end
		end
	end

	// Drive the result from the head cell
	assign in_ready       = (state_q == srp_pkg::ST_LOAD);
	assign out_valid      = (state_q == srp_pkg::ST_EMIT);
	assign rect_index     = cells[0].idx;
	assign pos_x          = cells[0].x;
	assign pos_y          = cells[0].y;
	assign atlas_span     = aw_q;
	assign atlas_height   = cy_q + srp_pkg::Y_W'(shelf_q);
	assign is_last_result = (rem_q == CNT_W'(1));

`ifndef SYNTHESIS
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cells[0].valid)
		else $error("result shown from an empty head cell");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECTS))
		else $error("rectangle count above capacity");
	a_last_returns: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && is_last_result) |=> (in_ready && count_q == '0))
		else $error("load state not cleared after final result");
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> rem_q != '0)
		else $error("result shown with no results remaining");
`endif

endmodule

### hdl/srp_cell.sv
// One cell of the sorted rectangle chain: insert by height, shift toward head.
// Depends on srp_pkg.
module srp_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  srp_pkg::cell_ctl_t ctl,
	input  srp_pkg::rect_t    new_item,
	input  srp_pkg::rect_t    up_item,
	input  logic              up_take,
	input  srp_pkg::rect_t    dn_item,
	output srp_pkg::rect_t    item,
	output logic              take
);

	srp_pkg::rect_t item_q;

	// Take the new request when empty or when it is at least as tall
	assign take = ctl.ins_en && (!item_q.valid || new_item.h >= item_q.h);
	assign item = item_q;

	// Hold, take from upstream, take the new request, or advance toward head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q.valid <= 1'b0;
		end else if (ctl.shift_en) begin
			item_q <= dn_item;
		end else if (take) begin
			item_q <= up_take ? up_item : new_item;
		end
	end

endmodule

### hdl/srp_sqrt.sv
// Bit-serial integer square root with ceiling, one result bit per cycle.
// Depends on srp_pkg.
module srp_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [srp_pkg::AREA_W-1:0]    value,
	output logic                          done,
	output logic [srp_pkg::ROOT_W-1:0]    root
);

	localparam int W = srp_pkg::AREA_W + 1;
	localparam logic [W-1:0] ONE_TOP = W'(1) << (srp_pkg::AREA_W - 2);

	logic [W-1:0] op_q, res_q, one_q;
	logic         busy_q, done_q;
	logic [W-1:0] trial;

	assign trial = res_q + one_q;

	// Iterate one result bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				op_q   <= W'(value);
				res_q  <= '0;
				one_q  <= ONE_TOP;
			end else if (busy_q) begin
				if (op_q >= trial) begin
					op_q  <= op_q - trial;
					res_q <= (res_q >> 1) + one_q;
				end else begin
					res_q <= res_q >> 1;
				end
				one_q <= one_q >> 2;
				if (one_q == W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Round up when a remainder is left
	assign done = done_q;
	assign root = res_q[srp_pkg::ROOT_W-1:0] + srp_pkg::ROOT_W'(op_q != '0);

endmodule
